### hdl/i2cmts_pkg.sv
package i2cmts_pkg;

   // sub-address and length sizing
   localparam int MAX_SUB_BYTES = 4;
   localparam int LENGTH_BITS   = 16;
   localparam int SUB_CNT_BITS  = 3;
   localparam int SUB_IDX_BITS  = (MAX_SUB_BYTES > 1) ? $clog2(MAX_SUB_BYTES) : 1;

   // request kinds
   localparam logic REQ_START     = 1'b0;
   localparam logic REQ_BYTE_DONE = 1'b1;

   // bus commands
   localparam logic [2:0] CMD_NONE    = 3'd0;
   localparam logic [2:0] CMD_START   = 3'd1;
   localparam logic [2:0] CMD_SEND    = 3'd2;
   localparam logic [2:0] CMD_RESTART = 3'd3;
   localparam logic [2:0] CMD_RX_ACK  = 3'd4;
   localparam logic [2:0] CMD_RX_NACK = 3'd5;
   localparam logic [2:0] CMD_STOP    = 3'd6;

   // completion status
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BUSY     = 3'd1;
   localparam logic [2:0] ST_ARB      = 3'd2;
   localparam logic [2:0] ST_NAK      = 3'd3;
   localparam logic [2:0] ST_ADDR_NAK = 3'd4;

   typedef struct packed {
      logic        req_type;
      logic        bus_busy;
      logic [6:0]  slave_address;
      logic        read_dir;
      logic [31:0] sub_address;
      logic [2:0]  sub_length;
      logic [15:0] data_length;
      logic        ack_missing;
      logic        arb_lost;
      logic [7:0]  rx_byte;
      logic [7:0]  tx_byte;
   } req_word_type;

   typedef struct packed {
      logic [2:0] bus_cmd;
      logic [7:0] bus_byte;
      logic       rx_valid;
      logic [7:0] rx_data;
      logic [2:0] status;
      logic       done_res;
   } rsp_word_type;

endpackage

### hdl/i2cmts_seq.sv
module i2cmts_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  i2cmts_pkg::req_word_type req_word,
   output i2cmts_pkg::rsp_word_type rsp_word
);

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_ADDR    = 3'd1,
      PH_SUB     = 3'd2,
      PH_RESTART = 3'd3,
      PH_WRITE   = 3'd4,
      PH_READ    = 3'd5
   } phase_type;

   phase_type                              phase_ff, phase_in;
   logic [6:0]                             target_address_ff, target_address_in;
   logic                                   read_request_ff, read_request_in;
   logic [31:0]                            sub_addr_value_ff, sub_addr_value_in;
   logic [i2cmts_pkg::SUB_CNT_BITS-1:0]    sub_bytes_left_ff, sub_bytes_left_in;
   logic [i2cmts_pkg::LENGTH_BITS-1:0]     bytes_left_ff, bytes_left_in;

   logic [i2cmts_pkg::SUB_CNT_BITS-1:0]    sub_len_sat;
   logic [i2cmts_pkg::SUB_CNT_BITS-1:0]    sub_left_dec;
   logic [i2cmts_pkg::SUB_IDX_BITS-1:0]    sub_idx;
   logic [i2cmts_pkg::LENGTH_BITS-1:0]     bytes_left_dec;
   logic                                   last_byte;

   // saturate the sub-address length
   assign sub_len_sat = (req_word.sub_length >
                         i2cmts_pkg::SUB_CNT_BITS'(i2cmts_pkg::MAX_SUB_BYTES))
                        ? i2cmts_pkg::SUB_CNT_BITS'(i2cmts_pkg::MAX_SUB_BYTES)
                        : req_word.sub_length;

   assign sub_left_dec   = sub_bytes_left_ff - 1'b1;
   assign sub_idx        = sub_left_dec[i2cmts_pkg::SUB_IDX_BITS-1:0];
   assign bytes_left_dec = bytes_left_ff - 1'b1;
   assign last_byte      = (bytes_left_ff == i2cmts_pkg::LENGTH_BITS'(1));

   always_comb begin
      phase_in          = phase_ff;
      target_address_in = target_address_ff;
      read_request_in   = read_request_ff;
      sub_addr_value_in = sub_addr_value_ff;
      sub_bytes_left_in = sub_bytes_left_ff;
      bytes_left_in     = bytes_left_ff;
      rsp_word          = '0;

      if (req_word.req_type == i2cmts_pkg::REQ_START) begin
         if (phase_ff != PH_IDLE) begin
            rsp_word.bus_cmd = i2cmts_pkg::CMD_NONE;
         end else if (req_word.bus_busy) begin
            rsp_word.status   = i2cmts_pkg::ST_BUSY;
            rsp_word.done_res = 1'b1;
         end else begin
            target_address_in = req_word.slave_address;
            read_request_in   = req_word.read_dir;
            sub_addr_value_in = req_word.sub_address;
            sub_bytes_left_in = sub_len_sat;
            bytes_left_in     = i2cmts_pkg::LENGTH_BITS'(req_word.data_length);
            phase_in          = PH_ADDR;
            rsp_word.bus_cmd  = i2cmts_pkg::CMD_START;
            // with a sub-address the first address always goes out as a write
            rsp_word.bus_byte = {req_word.slave_address,
                                 (sub_len_sat == '0) ? req_word.read_dir : 1'b0};
         end
      end else if (phase_ff == PH_IDLE) begin
         rsp_word.bus_cmd = i2cmts_pkg::CMD_NONE;
      end else if (phase_ff == PH_READ) begin
         // receive outcome flags are ignored
         rsp_word.rx_valid = 1'b1;
         rsp_word.rx_data  = req_word.rx_byte;
         if (bytes_left_ff == '0) begin
            phase_in          = PH_IDLE;
            rsp_word.bus_cmd  = i2cmts_pkg::CMD_STOP;
            rsp_word.done_res = 1'b1;
         end else begin
            bytes_left_in    = bytes_left_dec;
            rsp_word.bus_cmd = last_byte ? i2cmts_pkg::CMD_RX_NACK
                                         : i2cmts_pkg::CMD_RX_ACK;
         end
      end else if (req_word.arb_lost || req_word.ack_missing) begin
         phase_in          = PH_IDLE;
         rsp_word.bus_cmd  = i2cmts_pkg::CMD_STOP;
         rsp_word.done_res = 1'b1;
         if (req_word.arb_lost) begin
            rsp_word.status = i2cmts_pkg::ST_ARB;
         end else if (phase_ff == PH_RESTART) begin
            rsp_word.status = i2cmts_pkg::ST_ADDR_NAK;
         end else begin
            rsp_word.status = i2cmts_pkg::ST_NAK;
         end
      end else begin
         case (phase_ff)
            PH_ADDR, PH_SUB, PH_RESTART: begin
               if (phase_ff != PH_RESTART && sub_bytes_left_ff != '0) begin
                  // sub-address bytes, most significant first
                  sub_bytes_left_in = sub_left_dec;
                  phase_in          = PH_SUB;
                  rsp_word.bus_cmd  = i2cmts_pkg::CMD_SEND;
                  rsp_word.bus_byte = sub_addr_value_ff[8*sub_idx +: 8];
               end else if (phase_ff == PH_SUB && read_request_ff) begin
                  phase_in          = PH_RESTART;
                  rsp_word.bus_cmd  = i2cmts_pkg::CMD_RESTART;
                  rsp_word.bus_byte = {target_address_ff, 1'b1};
               end else if (bytes_left_ff == '0) begin
                  // empty data phase still closes with stop
                  phase_in          = PH_IDLE;
                  rsp_word.bus_cmd  = i2cmts_pkg::CMD_STOP;
                  rsp_word.done_res = 1'b1;
               end else if (read_request_ff) begin
                  bytes_left_in    = bytes_left_dec;
                  phase_in         = PH_READ;
                  rsp_word.bus_cmd = last_byte ? i2cmts_pkg::CMD_RX_NACK
                                               : i2cmts_pkg::CMD_RX_ACK;
               end else begin
                  bytes_left_in     = bytes_left_dec;
                  phase_in          = PH_WRITE;
                  rsp_word.bus_cmd  = i2cmts_pkg::CMD_SEND;
                  rsp_word.bus_byte = req_word.tx_byte;
               end
            end
            PH_WRITE: begin
               if (bytes_left_ff == '0) begin
                  phase_in          = PH_IDLE;
                  rsp_word.bus_cmd  = i2cmts_pkg::CMD_STOP;
                  rsp_word.done_res = 1'b1;
               end else begin
                  bytes_left_in     = bytes_left_dec;
                  rsp_word.bus_cmd  = i2cmts_pkg::CMD_SEND;
                  rsp_word.bus_byte = req_word.tx_byte;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         target_address_ff <= '0;
         read_request_ff   <= 1'b0;
         sub_addr_value_ff <= '0;
         sub_bytes_left_ff <= '0;
         bytes_left_ff     <= '0;
      end else if (step) begin
         phase_ff          <= phase_in;
         target_address_ff <= target_address_in;
         read_request_ff   <= read_request_in;
         sub_addr_value_ff <= sub_addr_value_in;
         sub_bytes_left_ff <= sub_bytes_left_in;
         bytes_left_ff     <= bytes_left_in;
      end
   end

endmodule

### hdl/i2c_master_transaction_sequencer.sv
// byte-level i2c master sequencer: each request word (a start request or a
// byte-done event from the bus engine) produces exactly one response word with
// the next bus command, any received byte and, when the transaction ends, its
// status. one word is taken every clock cycle while the response side is not
// stalled; a word passes through an input register and then a response register
// before its response is offered.
// while a response waits, one more
// request word can sit in the input register before req_ready drops. the
// sequencer state (phase, latched address, sub-address and byte counters) is
// updated when a word moves from the input register to the response register.
// no start-up sweep is needed after reset.
module i2c_master_transaction_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  i2cmts_pkg::req_word_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output i2cmts_pkg::rsp_word_type rsp_data
);

   // input register
   logic                     req_valid_ff, req_valid_in;
   i2cmts_pkg::req_word_type req_data_ff;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   i2cmts_pkg::rsp_word_type rsp_data_ff;

   i2cmts_pkg::rsp_word_type seq_rsp;
   logic                     rsp_free;
   logic                     step;

   // response slot is free when empty or being taken this cycle
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   // the held word moves on whenever the response slot frees up
   assign step      = req_valid_ff && rsp_free;
   assign req_ready = !req_valid_ff || rsp_free;

   assign req_valid_in = req_ready ? req_valid : req_valid_ff;
   assign rsp_valid_in = rsp_free ? req_valid_ff : rsp_valid_ff;

   // sequencing logic and transaction state
   i2cmts_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .req_word (req_data_ff),
      .rsp_word (seq_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_ready) begin
         req_data_ff <= req_data;
      end
      if (step) begin
         rsp_data_ff <= seq_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### test/i2c_master_transaction_sequencer_test.sv
`timescale 1ns / 100ps

module i2c_master_transaction_sequencer_test;

   // transfer phases as the sequencer walks through them
   typedef enum logic [2:0] {
      PH_IDLE, PH_ADDR, PH_SUB, PH_RESTART, PH_WRITE, PH_READ
   } phase_type;

   // cycles without any handshake before the run is declared hung
   localparam int HANG_LIMIT = 5000;
   // the response trails its request word through the input and response registers
   localparam int DRAIN_CYCLES = 10;
   localparam int WORD_TARGET = 1000;

   // keeps its own copy of the transfer state, works out the response word
   // that each accepted request word should produce and holds those in order
   class bus_command_scoreboard;
      phase_type                phase;
      logic [6:0]               target_address;
      logic                     read_request;
      logic [31:0]              sub_value;
      logic [2:0]               sub_left;
      logic [15:0]              bytes_left;
      i2cmts_pkg::rsp_word_type expected_words[$];
      int                       errors;
      int                       checked;

      function new();
         phase          = PH_IDLE;
         target_address = '0;
         read_request   = 1'b0;
         sub_value      = '0;
         sub_left       = '0;
         bytes_left     = '0;
         errors         = 0;
         checked        = 0;
      endfunction

      function i2cmts_pkg::rsp_word_type first_data_command(logic [7:0] tx);
         i2cmts_pkg::rsp_word_type r;
         r = '0;
         if (bytes_left == 0) begin
            phase      = PH_IDLE;
            r.bus_cmd  = i2cmts_pkg::CMD_STOP;
            r.done_res = 1'b1;
         end else if (read_request) begin
            r.bus_cmd  = (bytes_left == 1) ? i2cmts_pkg::CMD_RX_NACK
                                           : i2cmts_pkg::CMD_RX_ACK;
            bytes_left = bytes_left - 1'b1;
            phase      = PH_READ;
         end else begin
            r.bus_cmd  = i2cmts_pkg::CMD_SEND;
            r.bus_byte = tx;
            bytes_left = bytes_left - 1'b1;
            phase      = PH_WRITE;
         end
         return r;
      endfunction

      function i2cmts_pkg::rsp_word_type next_command(i2cmts_pkg::req_word_type w);
         i2cmts_pkg::rsp_word_type r;
         logic [2:0]               slen;
         r = '0;
         if (w.req_type == i2cmts_pkg::REQ_START) begin
            if (phase != PH_IDLE)
               return r;
            if (w.bus_busy) begin
               r.status   = i2cmts_pkg::ST_BUSY;
               r.done_res = 1'b1;
               return r;
            end
            slen = (w.sub_length > i2cmts_pkg::MAX_SUB_BYTES)
                   ? 3'(i2cmts_pkg::MAX_SUB_BYTES) : w.sub_length;
            target_address = w.slave_address;
            read_request   = w.read_dir;
            sub_value      = w.sub_address;
            sub_left       = slen;
            bytes_left     = w.data_length;
            phase          = PH_ADDR;
            r.bus_cmd      = i2cmts_pkg::CMD_START;
            r.bus_byte     = {w.slave_address, (slen != 0) ? 1'b0 : w.read_dir};
            return r;
         end
         if (phase == PH_IDLE)
            return r;
         if (phase == PH_READ) begin
            r.rx_valid = 1'b1;
            r.rx_data  = w.rx_byte;
            if (bytes_left == 0) begin
               phase      = PH_IDLE;
               r.bus_cmd  = i2cmts_pkg::CMD_STOP;
               r.done_res = 1'b1;
            end else begin
               r.bus_cmd  = (bytes_left == 1) ? i2cmts_pkg::CMD_RX_NACK
                                              : i2cmts_pkg::CMD_RX_ACK;
               bytes_left = bytes_left - 1'b1;
            end
            return r;
         end
         if (w.arb_lost || w.ack_missing) begin
            r.status   = w.arb_lost ? i2cmts_pkg::ST_ARB
                       : ((phase == PH_RESTART) ? i2cmts_pkg::ST_ADDR_NAK
                                                : i2cmts_pkg::ST_NAK);
            r.bus_cmd  = i2cmts_pkg::CMD_STOP;
            r.done_res = 1'b1;
            phase      = PH_IDLE;
            return r;
         end
         case (phase)
            PH_ADDR, PH_SUB: begin
               if (sub_left != 0) begin
                  sub_left   = sub_left - 1'b1;
                  r.bus_cmd  = i2cmts_pkg::CMD_SEND;
                  r.bus_byte = sub_value[8 * sub_left +: 8];
                  phase      = PH_SUB;
               end else if (phase == PH_SUB && read_request) begin
                  r.bus_cmd  = i2cmts_pkg::CMD_RESTART;
                  r.bus_byte = {target_address, 1'b1};
                  phase      = PH_RESTART;
               end else begin
                  r = first_data_command(w.tx_byte);
               end
            end
            PH_RESTART: r = first_data_command(w.tx_byte);
            PH_WRITE: begin
               if (bytes_left == 0) begin
                  phase      = PH_IDLE;
                  r.bus_cmd  = i2cmts_pkg::CMD_STOP;
                  r.done_res = 1'b1;
               end else begin
                  bytes_left = bytes_left - 1'b1;
                  r.bus_cmd  = i2cmts_pkg::CMD_SEND;
                  r.bus_byte = w.tx_byte;
               end
            end
            default: phase = PH_IDLE;
         endcase
         return r;
      endfunction

      // returns 1 when the sequencer is expected to ignore the word
      function bit note_word(i2cmts_pkg::req_word_type w);
         bit ignored;
         ignored = (w.req_type == i2cmts_pkg::REQ_START) ? (phase != PH_IDLE)
                                                         : (phase == PH_IDLE);
         expected_words.push_back(next_command(w));
         return ignored;
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            if (errors < 40)
               $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         end
      endfunction

      function void check_word(i2cmts_pkg::rsp_word_type got);
         i2cmts_pkg::rsp_word_type want;
         if (expected_words.size() == 0) begin
            errors++;
            if (errors < 40)
               $display("%0t: response expected none got %0h", $time, got);
            return;
         end
         want = expected_words.pop_front();
         checked++;
         compare_field("bus_cmd", 32'(want.bus_cmd), 32'(got.bus_cmd));
         compare_field("bus_byte", 32'(want.bus_byte), 32'(got.bus_byte));
         compare_field("rx_valid", 32'(want.rx_valid), 32'(got.rx_valid));
         compare_field("rx_data", 32'(want.rx_data), 32'(got.rx_data));
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("done_res", 32'(want.done_res), 32'(got.done_res));
      endfunction
   endclass

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   i2cmts_pkg::req_word_type req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   i2cmts_pkg::rsp_word_type rsp_data;

   bus_command_scoreboard board = new();

   int          words_counted = 0;   // words that the sequencer acts upon
   int          words_sent    = 0;
   int          transfers     = 0;
   int          burst_left    = 0;
   int          stall_left    = 0;
   int          idle_cycles   = 0;
   int unsigned cycle_count   = 0;

   i2c_master_transaction_sequencer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: checks each accepted word, then picks the next ready level.
   // the stall behaviour steps through four modes picked from the cycle counter:
   // always ready, coin toss, occasional long stalls, mostly ready
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && rsp_valid && rsp_ready)
         board.check_word(rsp_data);
      case (cycle_count[8:7])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= 1'($urandom_range(0, 1));
         2'd2: begin
            if (stall_left != 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
               stall_left = $urandom_range(1, 12);
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
         default: rsp_ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // hang detection: any handshake on either side clears the count
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= HANG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
         $display("i2c_master_transaction_sequencer_test: errors");
         $finish;
      end
   end

   // every field random, used as the base of all words
   function automatic i2cmts_pkg::req_word_type random_word();
      logic [95:0] bits;
      bits = {$urandom, $urandom, $urandom};
      return bits[$bits(i2cmts_pkg::req_word_type)-1:0];
   endfunction

   function automatic i2cmts_pkg::req_word_type start_word(logic [6:0] addr, logic rdir,
                                                           logic [31:0] sub,
                                                           logic [2:0] slen,
                                                           logic [15:0] dlen,
                                                           logic busy);
      i2cmts_pkg::req_word_type w;
      w               = random_word();
      w.req_type      = i2cmts_pkg::REQ_START;
      w.bus_busy      = busy;
      w.slave_address = addr;
      w.read_dir      = rdir;
      w.sub_address   = sub;
      w.sub_length    = slen;
      w.data_length   = dlen;
      return w;
   endfunction

   function automatic i2cmts_pkg::req_word_type done_word(logic nack, logic arb,
                                                          logic [7:0] rx,
                                                          logic [7:0] tx);
      i2cmts_pkg::req_word_type w;
      w             = random_word();
      w.req_type    = i2cmts_pkg::REQ_BYTE_DONE;
      w.ack_missing = nack;
      w.arb_lost    = arb;
      w.rx_byte     = rx;
      w.tx_byte     = tx;
      return w;
   endfunction

   // request side: bursts of back-to-back words separated by random gaps.
   // valid is raised at a rising edge and held until the word is taken
   task automatic send_word(i2cmts_pkg::req_word_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= w;
      do
         @(posedge clock);
      while (!req_ready);
      words_sent++;
      if (!board.note_word(w))
         words_counted++;
   endtask

   // one complete transfer: a start followed by byte-done events until the
   // sequencer returns to idle, with the odd error and ignored start mixed in
   task automatic run_transfer();
      i2cmts_pkg::req_word_type w;
      bit                       lengthy;
      int                       events;
      lengthy = ($urandom_range(0, 7) == 0);
      w = start_word(7'($urandom), 1'($urandom),  $urandom,
                     ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 4)),
                     16'($urandom_range(0, 6)), 1'b0);
      // long writes carry the full length range and end on a forced nak
      if (lengthy) begin
         w.read_dir    = 1'b0;
         w.data_length = 16'($urandom);
      end
      send_word(w);
      transfers++;
      events = 0;
      while (board.phase != PH_IDLE) begin
         if ($urandom_range(0, 24) == 0) begin
            w          = random_word();
            w.req_type = i2cmts_pkg::REQ_START;
         end else begin
            w = done_word($urandom_range(0, 39) == 0, $urandom_range(0, 39) == 0,
                          8'($urandom), 8'($urandom));
            if (lengthy && events > 16)
               w.ack_missing = 1'b1;
            events++;
         end
         send_word(w);
      end
   endtask

   initial begin
      i2cmts_pkg::req_word_type w;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // event while idle, then a refused start on a busy bus
      send_word(done_word(1'b1, 1'b1, 8'hff, 8'hff));
      send_word(start_word(7'h7f, 1'b1, 32'hffff_ffff, 3'd7, 16'hffff, 1'b1));

      // read with an over-long sub-address: four bytes, restart, ack then nack
      send_word(start_word(7'h7f, 1'b1, 32'h89ab_cdef, 3'd7, 16'd2, 1'b0));
      send_word(done_word(1'b0, 1'b0, 8'h00, 8'h00));
      send_word(start_word(7'h00, 1'b0, 32'h0, 3'd0, 16'd0, 1'b0)); // ignored while active
      send_word(done_word(1'b0, 1'b0, 8'h00, 8'h00));
      send_word(done_word(1'b0, 1'b0, 8'h00, 8'h00));
      send_word(done_word(1'b0, 1'b0, 8'h00, 8'h00));
      send_word(done_word(1'b0, 1'b0, 8'h00, 8'h00));
      send_word(done_word(1'b0, 1'b0, 8'h00, 8'h00));
      // errors are not looked at while receiving
      send_word(done_word(1'b1, 1'b1, 8'hff, 8'h00));
      send_word(done_word(1'b0, 1'b0, 8'h5a, 8'h00));

      // write with no sub-address and no data: straight to stop
      send_word(start_word(7'h00, 1'b0, 32'h0, 3'd0, 16'd0, 1'b0));
      send_word(done_word(1'b0, 1'b0, 8'h00, 8'hff));

      // single-byte read without sub-address
      send_word(start_word(7'h2a, 1'b1, 32'h0, 3'd0, 16'd1, 1'b0));
      send_word(done_word(1'b0, 1'b0, 8'h00, 8'h00));
      send_word(done_word(1'b0, 1'b0, 8'ha5, 8'h00));

      // arbitration lost on the address byte
      send_word(start_word(7'h55, 1'b0, 32'h1234_5678, 3'd1, 16'd4, 1'b0));
      send_word(done_word(1'b0, 1'b1, 8'h00, 8'h00));

      // nak after the repeated start
      send_word(start_word(7'h11, 1'b1, 32'h0000_00c3, 3'd1, 16'd3, 1'b0));
      send_word(done_word(1'b0, 1'b0, 8'h00, 8'h00));
      send_word(done_word(1'b0, 1'b0, 8'h00, 8'h00));
      send_word(done_word(1'b1, 1'b0, 8'h00, 8'h00));

      // nak during the sub-address of a maximum-length write
      send_word(start_word(7'h3c, 1'b0, 32'hffff_ffff, 3'd2, 16'hffff, 1'b0));
      send_word(done_word(1'b0, 1'b0, 8'h00, 8'h00));
      send_word(done_word(1'b1, 1'b0, 8'h00, 8'h00));

      // arbitration and nak together in the write phase
      send_word(start_word(7'h40, 1'b0, 32'h0, 3'd0, 16'd2, 1'b0));
      send_word(done_word(1'b0, 1'b0, 8'h00, 8'hc3));
      send_word(done_word(1'b1, 1'b1, 8'h00, 8'h3c));

      // random part: mostly whole transfers, some idle noise between them
      while (words_counted < WORD_TARGET) begin
         if ($urandom_range(0, 9) == 0) begin
            w = random_word();
            if (w.req_type == i2cmts_pkg::REQ_START)
               w.bus_busy = 1'b1;
            send_word(w);
         end else begin
            run_transfer();
         end
      end
      req_valid <= 1'b0;

      while (board.expected_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d request words sent over %0d transfers, %0d acted upon",
               words_sent, transfers, words_counted);
      $display("%0d response words checked, %0d mismatches", board.checked, board.errors);
      if (board.errors == 0)
         $display("i2c_master_transaction_sequencer_test: clean");
      else
         $display("i2c_master_transaction_sequencer_test: errors");
      $finish;
   end

endmodule
